// ----- rtl/core/sha1_stream_hasher_assert.svh -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SHA1SH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SHA1SH_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/core/sha1sh_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher package
// Constants, word types and the command and status records that connect
// the controller, the datapath and the digest buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlockBits  = 512;
  localparam int unsigned LastRound  = 79;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] chain_t;

  localparam chain_t IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [5:0] LenPos   = 6'd56;
  localparam logic [5:0] FillLast = 6'd63;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Round group selects the boolean function and the round constant.
  typedef enum logic [1:0] {
    GRP_CH  = 2'd0,
    GRP_PA1 = 2'd1,
    GRP_MAJ = 2'd2,
    GRP_PA2 = 2'd3
  } round_grp_t;

  typedef struct packed {
    logic       push;       // shift one byte into the block buffer
    byte_src_t  src;
    logic       start;      // copy chain words into the working registers
    logic       round;      // run one compression round
    round_grp_t grp;
    logic       add;        // fold working registers into the chain
    logic       final_blk;  // last block of a message: publish and restart
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sha1_stream_hasher.sv -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher
// Streaming SHA-1 engine: bytes in, five 32-bit digest words out.
// ---------------------------------------------------------------------------
// Usage. The slave channel carries one word per message byte: tuser low
// absorbs tdata as the next byte, tuser high closes the message. A closed
// message is padded with a 0x80 byte, zeros and the 64-bit bit length, and
// its digest leaves on the master channel as five words, word 0 first, with
// tlast on the fifth. The engine then starts a new message on its own.
// Flow control: s_tready is high while the engine absorbs. The 64th byte
// of a block also loads the working registers and starts a compression
// that holds s_tready low through 80 rounds in a single round unit and
// one chain update. A finish feeds one padding byte per cycle up to the
// block end and compresses once or twice; the length needs a padding
// block of its own when 56 or more bytes are in the block at the finish.
// The digest sits in its own buffer and leaves one word per cycle while
// m_tready is high, so the next message is absorbed while the receiver
// stalls; only the next digest waits for that buffer to empty.
// Reset (rst, synchronous, active high) restores the initial chain values
// and clears the byte count and the digest buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  wire logic        s_tuser,   // [0] cmd: 0 absorb, 1 finish
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
  output logic             m_tlast    // last_word
);

  sha1sh_pkg::dp_cmd_t  cmd;
  sha1sh_pkg::dp_stat_t stat;
  sha1sh_pkg::chain_t   digest;
  logic [5:0]           fill;
  logic                 out_busy;

  assign stat.fill     = fill;
  assign stat.out_busy = out_busy;
  assign m_tvalid      = out_busy;

  sha1sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_byte (s_tdata),
    .cmd     (cmd),
    .fill    (fill),
    .digest  (digest)
  );

  // The digest is captured when the last block folds into the chain.
  sha1sh_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.add && cmd.final_blk),
    .digest    (digest),
    .busy      (out_busy),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_ready (m_tready)
  );

endmodule

`default_nettype wire

// ----- rtl/core/sha1sh_ctrl.sv -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher controller
// Sequences byte intake, padding, the 80 rounds and the chain update.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sha1_stream_hasher_assert.svh"

module sha1sh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_cmd,
  output logic                     in_ready,
  input  wire sha1sh_pkg::dp_stat_t stat,
  output sha1sh_pkg::dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_ABSORB = 4'b0001,
    ST_PAD    = 4'b0010,
    ST_ROUND  = 4'b0100,
    ST_ADD    = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [6:0] rnd, rnd_next;
  logic       pad_act, pad_act_next;
  logic       mark_done, mark_done_next;
  logic       len_phase, len_phase_next;
  logic       final_blk, final_blk_next;

  assign in_ready = (state == ST_ABSORB);

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    pad_act_next   = pad_act;
    mark_done_next = mark_done;
    len_phase_next = len_phase;
    final_blk_next = final_blk;
    cmd            = '0;
    cmd.src        = sha1sh_pkg::SRC_IN;
    cmd.grp        = sha1sh_pkg::GRP_CH;

    unique case (state)
      ST_ABSORB: begin
        if (in_valid) begin
          if (!in_cmd) begin
            cmd.push = 1'b1;
            if (stat.fill == sha1sh_pkg::FillLast) begin
              cmd.start      = 1'b1;
              final_blk_next = 1'b0;
              state_next     = ST_ROUND;
            end
          end else begin
            pad_act_next   = 1'b1;
            mark_done_next = 1'b0;
            len_phase_next = 1'b0;
            state_next     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (!mark_done) begin
          cmd.src = sha1sh_pkg::SRC_MARK;
        end else if (len_phase || (stat.fill == sha1sh_pkg::LenPos)) begin
          cmd.src = sha1sh_pkg::SRC_LEN;
        end else begin
          cmd.src = sha1sh_pkg::SRC_ZERO;
        end
        mark_done_next = 1'b1;
        if (cmd.src == sha1sh_pkg::SRC_LEN) begin
          len_phase_next = 1'b1;
        end
        if (stat.fill == sha1sh_pkg::FillLast) begin
          cmd.start      = 1'b1;
          final_blk_next = (cmd.src == sha1sh_pkg::SRC_LEN);
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (rnd < 7'd20) begin
          cmd.grp = sha1sh_pkg::GRP_CH;
        end else if (rnd < 7'd40) begin
          cmd.grp = sha1sh_pkg::GRP_PA1;
        end else if (rnd < 7'd60) begin
          cmd.grp = sha1sh_pkg::GRP_MAJ;
        end else begin
          cmd.grp = sha1sh_pkg::GRP_PA2;
        end
        if (rnd == 7'(sha1sh_pkg::LastRound)) begin
          rnd_next   = '0;
          state_next = ST_ADD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      ST_ADD: begin
        // The last block waits until the digest buffer has been drained.
        if (!(final_blk && stat.out_busy)) begin
          cmd.add       = 1'b1;
          cmd.final_blk = final_blk;
          if (final_blk) begin
            pad_act_next   = 1'b0;
            mark_done_next = 1'b0;
            len_phase_next = 1'b0;
            final_blk_next = 1'b0;
            state_next     = ST_ABSORB;
          end else if (pad_act) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_ABSORB;
          end
        end
      end
      default: begin
        state_next = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ABSORB;
      rnd       <= '0;
      pad_act   <= 1'b0;
      mark_done <= 1'b0;
      len_phase <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      pad_act   <= pad_act_next;
      mark_done <= mark_done_next;
      len_phase <= len_phase_next;
      final_blk <= final_blk_next;
    end
  end

  `SHA1SH_ASSERT_ALWAYS(a_rnd_range, rnd <= 7'(sha1sh_pkg::LastRound), "round count out of range")
  `SHA1SH_ASSERT_NEXT(a_round_to_add, (state == ST_ROUND) && (rnd == 7'(sha1sh_pkg::LastRound)), state == ST_ADD, "last round not followed by chain update")
  `SHA1SH_ASSERT_ALWAYS(a_len_after_mark, !len_phase || mark_done, "length bytes before pad mark")
  `SHA1SH_ASSERT_ALWAYS(a_final_needs_len, !(cmd.add && cmd.final_blk) || len_phase, "final block without length field")
  `SHA1SH_ASSERT_NEXT(a_start_runs, cmd.start, (state == ST_ROUND) && (rnd == 7'd0), "block start did not begin rounds")

endmodule

`default_nettype wire

// ----- rtl/core/sha1sh_datapath.sv -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher datapath
// Block shift buffer that doubles as the 16-word schedule window, the
// working registers with one round unit, chain words and length counter.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1sh_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          in_byte,
  input  wire sha1sh_pkg::dp_cmd_t cmd,
  output logic [5:0]               fill,
  output sha1sh_pkg::chain_t       digest
);

  localparam int unsigned BB = sha1sh_pkg::BlockBits;

  logic [BB-1:0]      blk;
  sha1sh_pkg::chain_t chain;
  sha1sh_pkg::chain_t work;
  logic [63:0]        byte_total;

  logic [63:0]        len_bits;
  logic [2:0]         len_sel;
  logic [7:0]         len_byte;
  logic [7:0]         push_byte;
  sha1sh_pkg::word_t  w0, w2, w8, w13, w_mix, w_new;
  sha1sh_pkg::word_t  a, b, c, d, e, f, k, t_sum;

  // The byte at the current fill position of the big-endian length field.
  assign len_bits = {byte_total[60:0], 3'b000};
  assign len_sel  = ~fill[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  always_comb begin
    case (cmd.src)
      sha1sh_pkg::SRC_IN:   push_byte = in_byte;
      sha1sh_pkg::SRC_MARK: push_byte = sha1sh_pkg::PadMark;
      sha1sh_pkg::SRC_ZERO: push_byte = 8'h00;
      sha1sh_pkg::SRC_LEN:  push_byte = len_byte;
      default:              push_byte = 8'h00;
    endcase
  end

  // Window word i sits at blk[511-32*i -: 32]; word 0 is the current w[t].
  assign w0    = blk[BB-1      -: 32];
  assign w2    = blk[BB-1-64   -: 32];
  assign w8    = blk[BB-1-256  -: 32];
  assign w13   = blk[BB-1-416  -: 32];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];
  assign e = work[4];

  always_comb begin
    case (cmd.grp)
      sha1sh_pkg::GRP_CH: begin
        f = (b & c) | (~b & d);
        k = sha1sh_pkg::K0;
      end
      sha1sh_pkg::GRP_PA1: begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K1;
      end
      sha1sh_pkg::GRP_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1sh_pkg::K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K3;
      end
    endcase
  end

  assign t_sum = {a[26:0], a[31:27]} + f + e + k + w0;

  for (genvar i = 0; i < sha1sh_pkg::NumWords; i++) begin : g_sum
    assign digest[i] = chain[i] + work[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[BB-9:0], push_byte};
    end else if (cmd.round) begin
      blk <= {blk[BB-33:0], w_new};
    end
    if (cmd.start) begin
      work <= chain;
    end else if (cmd.round) begin
      work[0] <= t_sum;
      work[1] <= a;
      work[2] <= {b[1:0], b[31:2]};
      work[3] <= c;
      work[4] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= sha1sh_pkg::IV;
      fill       <= '0;
      byte_total <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.push && (cmd.src == sha1sh_pkg::SRC_IN)) begin
        byte_total <= byte_total + 64'd1;
      end
      if (cmd.add) begin
        if (cmd.final_blk) begin
          chain      <= sha1sh_pkg::IV;
          byte_total <= '0;
        end else begin
          chain <= digest;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sha1sh_outbuf.sv -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher digest buffer
// Holds a finished digest and hands it out one word at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1sh_outbuf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire sha1sh_pkg::chain_t digest,
  output logic                    busy,
  output logic [39:0]             out_data,
  output logic                    out_last,
  input  wire logic               out_ready
);

  sha1sh_pkg::chain_t words;
  logic [2:0]         idx;
  logic               take;

  assign take     = busy && out_ready;
  assign out_last = (idx == 3'(sha1sh_pkg::NumWords - 1));
  assign out_data = {5'b00000, idx, words[0]};

  always_ff @(posedge clk) begin
    if (load) begin
      words <= digest;
    end else if (take) begin
      words <= {32'h0, words[sha1sh_pkg::NumWords-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
      if (out_last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/sha1_stream_hasher_test.sv -----
// ---------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Streams messages into the hasher byte by byte and closes each one with a
// finish word. Alongside the stream, a SHA-1 calculation built into the
// bench predicts the five digest words that each finish must produce. The
// monitor checks every digest word that leaves the block against that
// prediction. Both sides of the stream idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher_test;

  // Values of the command bit that travels on s_tuser.
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 300;
  localparam int IDLE_PCT    = 30;

  // One word for the slave side of the stream. When hold is set, the driver
  // does not present this word until every digest word that is owed has
  // arrived.
  typedef struct packed {
    logic       hold;
    logic       cmd;
    logic [7:0] data;
  } feed_word_t;

  // One predicted digest word, in the order the fields leave the block.
  typedef struct packed {
    sha1sh_pkg::word_t digest;
    logic [2:0]        pos;
    logic              last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = CMD_ABSORB;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  sha1_stream_hasher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  feed_word_t   feed_q[$];      // words still to be sent
  digest_word_t digest_q[$];    // digest words owed by the block, oldest first
  feed_word_t   next_word;
  int           sent_count = 0;
  int           fault_count = 0;
  int           cycle_count = 0;

  // During this stretch of accepted words neither side idles, so block
  // loads and compressions also run back to back.
  wire calm = (sent_count >= 120) && (sent_count < 180);

  // -------------------------------------------------------------------------
  // SHA-1 calculation that tracks the block. It keeps its own chaining
  // words, block buffer, fill count and message byte count.
  // -------------------------------------------------------------------------
  sha1sh_pkg::chain_t hash_chain = sha1sh_pkg::IV;
  logic [7:0]         hash_block [64];
  logic [5:0]         hash_fill = 6'd0;
  logic [63:0]        hash_total = 64'd0;

  // The 80-round compression of the full block buffer into the chain.
  function automatic void compress_block();
    sha1sh_pkg::word_t sched [80];
    sha1sh_pkg::word_t a, b, c, d, e, f, k, t;
    int                r;
    for (r = 0; r < 16; r++) begin
      sched[r] = {hash_block[4*r], hash_block[4*r+1], hash_block[4*r+2], hash_block[4*r+3]};
    end
    for (r = 16; r < 80; r++) begin
      t = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
      sched[r] = {t[30:0], t[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1sh_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1sh_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1sh_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + sched[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_chain[0] = hash_chain[0] + a;
    hash_chain[1] = hash_chain[1] + b;
    hash_chain[2] = hash_chain[2] + c;
    hash_chain[3] = hash_chain[3] + d;
    hash_chain[4] = hash_chain[4] + e;
  endfunction

  // The fill count is six bits wide, so it wraps to zero exactly when the
  // block is full and due for compression.
  function automatic void push_block_byte(logic [7:0] b);
    hash_block[hash_fill] = b;
    hash_fill = hash_fill + 6'd1;
    if (hash_fill == 6'd0) begin
      compress_block();
    end
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    hash_total = hash_total + 64'd1;
    push_block_byte(b);
  endfunction

  // Pads the message, queues the five digest words it yields and starts a
  // new message. Padding bytes do not count toward the message length.
  function automatic void close_message();
    logic [63:0] bit_len;
    digest_word_t w;
    bit_len = hash_total << 3;
    push_block_byte(sha1sh_pkg::PadMark);
    while (hash_fill != sha1sh_pkg::LenPos) begin
      push_block_byte(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      push_block_byte(bit_len[8*(7-i) +: 8]);
    end
    for (int i = 0; i < sha1sh_pkg::NumWords; i++) begin
      w.digest = hash_chain[i];
      w.pos    = 3'(i);
      w.last   = (i == sha1sh_pkg::NumWords - 1);
      digest_q = {digest_q, w};
    end
    hash_chain = sha1sh_pkg::IV;
    hash_fill  = 6'd0;
    hash_total = 64'd0;
  endfunction

  // Only the first ten faults are printed; the rest are just counted.
  function automatic void log_fault(string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic void add_word(logic cmd, logic [7:0] data, logic hold);
    feed_word_t fw;
    fw.hold = hold;
    fw.cmd  = cmd;
    fw.data = data;
    feed_q  = {feed_q, fw};
  endfunction

  // -------------------------------------------------------------------------
  // Driver. A word moves when s_tvalid and s_tready are both high at the
  // edge. It is fed into the tracking calculation at that edge, and the next
  // word, or an idle cycle, is chosen. A presented word stays on the bus
  // until it is taken.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_FINISH) begin
          close_message();
        end else begin
          absorb_byte(s_tdata);
        end
        sent_count <= sent_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && !(feed_q[0].hold && digest_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_word = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_word.cmd;
          s_tdata  <= next_word.data;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor. Each digest word that is taken is compared with the oldest
  // prediction. The unused upper bits of m_tdata must be zero.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          log_fault($sformatf("unexpected digest word %h pos %0d last %0b",
                              m_tdata[31:0], m_tdata[34:32], m_tlast));
        end else if (m_tdata[31:0] != digest_q[0].digest ||
                     m_tdata[34:32] != digest_q[0].pos ||
                     m_tlast != digest_q[0].last || m_tdata[39:35] != 5'd0) begin
          log_fault($sformatf("expected %h pos %0d last %0b, got %h pos %0d last %0b pad %h",
                              digest_q[0].digest, digest_q[0].pos, digest_q[0].last,
                              m_tdata[31:0], m_tdata[34:32], m_tlast, m_tdata[39:35]));
          void'(digest_q.pop_front());
        end else begin
          void'(digest_q.pop_front());
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog for a block that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run.
  // -------------------------------------------------------------------------
  initial begin
    int msg_num;
    int msg_len;
    int total_words;

    // Directed part. A finish right after reset hashes the empty message.
    // The data byte of a finish is ignored, so it carries odd values.
    add_word(CMD_FINISH, 8'hff, 1'b0);
    // The standard "abc" message.
    add_word(CMD_ABSORB, 8'h61, 1'b0);
    add_word(CMD_ABSORB, 8'h62, 1'b0);
    add_word(CMD_ABSORB, 8'h63, 1'b0);
    add_word(CMD_FINISH, 8'h00, 1'b0);
    // Extreme byte values, including one equal to the padding marker.
    add_word(CMD_ABSORB, 8'h00, 1'b0);
    add_word(CMD_ABSORB, 8'hff, 1'b0);
    add_word(CMD_ABSORB, 8'h80, 1'b0);
    add_word(CMD_FINISH, 8'h5a, 1'b0);
    add_word(CMD_ABSORB, 8'h01, 1'b0);
    add_word(CMD_FINISH, 8'ha5, 1'b0);

    // Random part: whole messages with random bytes. A few have lengths
    // at the padding boundaries: 55 bytes still fit the length in the same
    // block, 56 need a second block, 64 fill a block before padding starts.
    // The first message, and a later one, wait until the previous digest
    // has fully drained.
    msg_num = 0;
    total_words = feed_q.size();
    while (total_words < 230 || msg_num < 8) begin
      case (msg_num)
        1:       msg_len = 55;
        3:       msg_len = 56;
        5:       msg_len = 64;
        default: msg_len = $urandom_range(0, 12);
      endcase
      for (int i = 0; i < msg_len; i++) begin
        add_word(CMD_ABSORB, 8'($urandom_range(0, 255)),
                 (i == 0) && (msg_num == 0 || msg_num == 6));
      end
      add_word(CMD_FINISH, 8'($urandom_range(0, 255)),
               (msg_len == 0) && (msg_num == 0 || msg_num == 6));
      total_words = total_words + msg_len + 1;
      msg_num++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // All words taken and every owed digest word received, then a tail that
    // covers two compressions and the padding to catch stray output.
    while (feed_q.size() != 0 || s_tvalid || digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digest_q.size() != 0) begin
      log_fault($sformatf("%0d digest words never arrived", digest_q.size()));
    end
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sha1_stream_hasher.f -----
+incdir+rtl/core
rtl/core/sha1sh_pkg.sv
rtl/core/sha1sh_ctrl.sv
rtl/core/sha1sh_datapath.sv
rtl/core/sha1sh_outbuf.sv
rtl/core/sha1_stream_hasher.sv
sim/sha1_stream_hasher_test.sv
